>>> rtl/ordered_pair_multiset_assert.svh
// Assertion macros used by the block's top module.
// Each expects signals named clk and rst_n in the scope where it is used.
`ifndef ORDERED_PAIR_MULTISET_ASSERT_SVH
`define ORDERED_PAIR_MULTISET_ASSERT_SVH

// Same-cycle implication.
`define OPM_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define OPM_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/opm_pkg.sv
package opm_pkg;

  localparam int CAPACITY = 64;
  localparam int IDX_W    = $clog2(CAPACITY);
  localparam int FILL_W   = $clog2(CAPACITY + 1);
  localparam int CNT_W    = 16;

  localparam logic [1:0] CMD_INSERT = 2'd0;
  localparam logic [1:0] CMD_REMOVE = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE   = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_ABSENT = 2'd2;

  localparam logic [CNT_W-1:0] CNT_MAX = '1;

  typedef logic signed [32:0] sum_t;

  typedef struct packed {
    logic signed [31:0] a;
    logic signed [31:0] d;
    logic [CNT_W-1:0]   count;
  } slot_t;

  // Compare results for one table entry against the key and the two
  // neighbor candidates found so far.
  typedef struct packed {
    logic eq;
    logic below_key;
    logic above_key;
    logic above_lo;
    logic below_hi;
  } ord_flags_t;

  function automatic sum_t pair_sum(logic signed [31:0] a, logic signed [31:0] d);
    pair_sum = $signed({a[31], a}) + $signed({d[31], d});
  endfunction

  // True when pair 1 orders strictly below pair 2: by sum, then by a.
  function automatic logic pair_lt(sum_t s1, logic signed [31:0] a1,
                                   sum_t s2, logic signed [31:0] a2);
    pair_lt = (s1 < s2) || ((s1 == s2) && (a1 < a2));
  endfunction

endpackage

>>> rtl/opm_slot_mem.sv
module opm_slot_mem
  import opm_pkg::*;
(
  input  logic             clk,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  slot_t            wr_data,
  input  logic [IDX_W-1:0] rd_addr,
  output slot_t            rd_data
);

  slot_t mem [CAPACITY];
  slot_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

>>> rtl/opm_order_unit.sv
module opm_order_unit
  import opm_pkg::*;
(
  input  slot_t              entry,
  input  logic signed [31:0] key_a,
  input  sum_t               key_sum,
  input  logic signed [31:0] lo_a,
  input  sum_t               lo_sum,
  input  logic signed [31:0] hi_a,
  input  sum_t               hi_sum,
  output sum_t               entry_sum,
  output ord_flags_t         flags
);

  sum_t esum;

  assign esum      = pair_sum(entry.a, entry.d);
  assign entry_sum = esum;

  // Equal sums with equal first values mean the second values match too.
  always_comb begin
    flags.eq        = (esum == key_sum) && (entry.a == key_a);
    flags.below_key = pair_lt(esum, entry.a, key_sum, key_a);
    flags.above_key = pair_lt(key_sum, key_a, esum, entry.a);
    flags.above_lo  = pair_lt(lo_sum, lo_a, esum, entry.a);
    flags.below_hi  = pair_lt(esum, entry.a, hi_sum, hi_a);
  end

endmodule

>>> rtl/ordered_pair_multiset.sv
// Ordered pair multiset. Each command (insert, remove, query) walks the used
// table entries once through a single comparison unit, reading one entry per
// cycle from the slot memory. With a nonempty table the scan issues the reads,
// a drain state compares the last entry read, an update state applies the
// command and the result is registered. An empty table skips the scan and the
// drain state. Busy is high from the accept edge until the result strobe cycle,
// and the next item can be accepted at the edge that ends that cycle. The result
// appears for one cycle with out_valid and cannot be held off by the receiver,
// so it must be captured when the strobe is seen.
module ordered_pair_multiset
  import opm_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         in_cmd,
  input  logic signed [31:0] in_key_a,
  input  logic signed [31:0] in_key_d,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [CNT_W-1:0]   out_match_count,
  output logic               out_lower_found,
  output logic signed [31:0] out_lower_a,
  output logic signed [31:0] out_lower_d,
  output logic [CNT_W-1:0]   out_lower_count,
  output logic               out_upper_found,
  output logic signed [31:0] out_upper_a,
  output logic signed [31:0] out_upper_d,
  output logic [CNT_W-1:0]   out_upper_count
);

  `include "ordered_pair_multiset_assert.svh"

  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_DRAIN = 2'd2;
  localparam logic [1:0] S_UPD   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [FILL_W-1:0]  fill_r, fill_nxt;
  logic [IDX_W-1:0]   rd_idx_r, rd_idx_nxt;
  logic               cmp_vld_r, cmp_vld_nxt;
  logic [IDX_W-1:0]   cmp_idx_r, cmp_idx_nxt;

  logic [1:0]         cmd_r, cmd_nxt;
  logic signed [31:0] key_a_r, key_a_nxt;
  logic signed [31:0] key_d_r, key_d_nxt;
  sum_t               key_sum_r, key_sum_nxt;

  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_idx_r, hit_idx_nxt;
  logic [CNT_W-1:0]   hit_cnt_r, hit_cnt_nxt;

  logic               lo_found_r, lo_found_nxt;
  slot_t              lo_r, lo_nxt;
  sum_t               lo_sum_r, lo_sum_nxt;
  logic               hi_found_r, hi_found_nxt;
  slot_t              hi_r, hi_nxt;
  sum_t               hi_sum_r, hi_sum_nxt;

  logic               out_valid_r, out_valid_nxt;
  logic [1:0]         out_status_r, out_status_nxt;
  logic [CNT_W-1:0]   out_match_count_r, out_match_count_nxt;
  slot_t              out_lower_r, out_lower_nxt;
  slot_t              out_upper_r, out_upper_nxt;
  logic               out_lower_found_r, out_lower_found_nxt;
  logic               out_upper_found_r, out_upper_found_nxt;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  slot_t              wr_data;
  slot_t              rd_data;
  sum_t               entry_sum;
  ord_flags_t         flags;
  logic [CNT_W-1:0]   new_cnt;

  opm_slot_mem u_mem (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_idx_r),
    .rd_data (rd_data)
  );

  opm_order_unit u_order (
    .entry     (rd_data),
    .key_a     (key_a_r),
    .key_sum   (key_sum_r),
    .lo_a      (lo_r.a),
    .lo_sum    (lo_sum_r),
    .hi_a      (hi_r.a),
    .hi_sum    (hi_sum_r),
    .entry_sum (entry_sum),
    .flags     (flags)
  );

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt           = state_r;
    fill_nxt            = fill_r;
    rd_idx_nxt          = rd_idx_r;
    cmp_vld_nxt         = 1'b0;
    cmp_idx_nxt         = rd_idx_r;
    cmd_nxt             = cmd_r;
    key_a_nxt           = key_a_r;
    key_d_nxt           = key_d_r;
    key_sum_nxt         = key_sum_r;
    hit_nxt             = hit_r;
    hit_idx_nxt         = hit_idx_r;
    hit_cnt_nxt         = hit_cnt_r;
    lo_found_nxt        = lo_found_r;
    lo_nxt              = lo_r;
    lo_sum_nxt          = lo_sum_r;
    hi_found_nxt        = hi_found_r;
    hi_nxt              = hi_r;
    hi_sum_nxt          = hi_sum_r;
    out_valid_nxt       = 1'b0;
    out_status_nxt      = out_status_r;
    out_match_count_nxt = out_match_count_r;
    out_lower_nxt       = out_lower_r;
    out_upper_nxt       = out_upper_r;
    out_lower_found_nxt = out_lower_found_r;
    out_upper_found_nxt = out_upper_found_r;
    wr_en               = 1'b0;
    wr_addr             = hit_idx_r;
    wr_data             = '{a: key_a_r, d: key_d_r, count: hit_cnt_r};
    new_cnt             = hit_cnt_r;

    // One entry read last cycle is compared here. The entry that matches the
    // key is never a neighbor, so neighbor counts are final after the scan.
    if (cmp_vld_r) begin
      if (flags.eq) begin
        hit_nxt     = 1'b1;
        hit_idx_nxt = cmp_idx_r;
        hit_cnt_nxt = rd_data.count;
      end
      if (flags.below_key && (!lo_found_r || flags.above_lo)) begin
        lo_found_nxt = 1'b1;
        lo_nxt       = rd_data;
        lo_sum_nxt   = entry_sum;
      end
      if (flags.above_key && (!hi_found_r || flags.below_hi)) begin
        hi_found_nxt = 1'b1;
        hi_nxt       = rd_data;
        hi_sum_nxt   = entry_sum;
      end
    end

    case (state_r)
      S_IDLE: begin
        rd_idx_nxt = '0;
        if (start) begin
          cmd_nxt      = in_cmd;
          key_a_nxt    = in_key_a;
          key_d_nxt    = in_key_d;
          key_sum_nxt  = pair_sum(in_key_a, in_key_d);
          hit_nxt      = 1'b0;
          lo_found_nxt = 1'b0;
          hi_found_nxt = 1'b0;
          state_nxt    = (fill_r == '0) ? S_UPD : S_SCAN;
        end
      end
      S_SCAN: begin
        cmp_vld_nxt = 1'b1;
        rd_idx_nxt  = rd_idx_r + 1'b1;
        if (FILL_W'(rd_idx_r) + 1'b1 == fill_r) begin
          state_nxt = S_DRAIN;
        end
      end
      S_DRAIN: begin
        state_nxt = S_UPD;
      end
      S_UPD: begin
        out_status_nxt = ST_DONE;
        case (cmd_r)
          CMD_INSERT: begin
            if (hit_r) begin
              new_cnt = (hit_cnt_r == CNT_MAX) ? hit_cnt_r : hit_cnt_r + 1'b1;
              wr_en   = 1'b1;
              wr_data = '{a: key_a_r, d: key_d_r, count: new_cnt};
            end else if (fill_r == FILL_W'(CAPACITY)) begin
              out_status_nxt = ST_FULL;
              new_cnt        = '0;
            end else begin
              // Slots are never released, so the first free slot is the fill level.
              new_cnt  = CNT_W'(1);
              wr_en    = 1'b1;
              wr_addr  = fill_r[IDX_W-1:0];
              wr_data  = '{a: key_a_r, d: key_d_r, count: new_cnt};
              fill_nxt = fill_r + 1'b1;
            end
          end
          CMD_REMOVE: begin
            if (hit_r) begin
              new_cnt = (hit_cnt_r == '0) ? hit_cnt_r : hit_cnt_r - 1'b1;
              wr_en   = 1'b1;
              wr_data = '{a: key_a_r, d: key_d_r, count: new_cnt};
            end else begin
              out_status_nxt = ST_ABSENT;
              new_cnt        = '0;
            end
          end
          default: begin
            new_cnt = hit_r ? hit_cnt_r : '0;
          end
        endcase
        out_valid_nxt       = 1'b1;
        out_match_count_nxt = new_cnt;
        out_lower_found_nxt = lo_found_r;
        out_upper_found_nxt = hi_found_r;
        out_lower_nxt       = lo_found_r ? lo_r : '0;
        out_upper_nxt       = hi_found_r ? hi_r : '0;
        state_nxt           = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= '0;
      cmp_vld_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
    rd_idx_r          <= rd_idx_nxt;
    cmp_idx_r         <= cmp_idx_nxt;
    cmd_r             <= cmd_nxt;
    key_a_r           <= key_a_nxt;
    key_d_r           <= key_d_nxt;
    key_sum_r         <= key_sum_nxt;
    hit_r             <= hit_nxt;
    hit_idx_r         <= hit_idx_nxt;
    hit_cnt_r         <= hit_cnt_nxt;
    lo_found_r        <= lo_found_nxt;
    lo_r              <= lo_nxt;
    lo_sum_r          <= lo_sum_nxt;
    hi_found_r        <= hi_found_nxt;
    hi_r              <= hi_nxt;
    hi_sum_r          <= hi_sum_nxt;
    out_status_r      <= out_status_nxt;
    out_match_count_r <= out_match_count_nxt;
    out_lower_r       <= out_lower_nxt;
    out_upper_r       <= out_upper_nxt;
    out_lower_found_r <= out_lower_found_nxt;
    out_upper_found_r <= out_upper_found_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_match_count = out_match_count_r;
  assign out_lower_found = out_lower_found_r;
  assign out_lower_a     = out_lower_r.a;
  assign out_lower_d     = out_lower_r.d;
  assign out_lower_count = out_lower_r.count;
  assign out_upper_found = out_upper_found_r;
  assign out_upper_a     = out_upper_r.a;
  assign out_upper_d     = out_upper_r.d;
  assign out_upper_count = out_upper_r.count;

  `OPM_ASSERT_NXT(a_single_result, out_valid_r, !out_valid_r, "result strobe longer than one cycle")
  `OPM_ASSERT_NXT(a_busy_after_accept, start && !busy, busy, "accepted item did not raise busy")
  `OPM_ASSERT_IMP(a_fill_bound, 1'b1, fill_r <= FILL_W'(CAPACITY), "fill level beyond capacity")
  `OPM_ASSERT_IMP(a_scan_in_range, cmp_vld_r, FILL_W'(cmp_idx_r) < fill_r, "scan read an unused slot")
  `OPM_ASSERT_IMP(a_full_no_count, out_valid_r && (out_status_r == ST_FULL), out_match_count_r == '0, "full insert reported a count")

endmodule

>>> dv/ordered_pair_multiset_tb.sv
`timescale 1ns / 1ps

module ordered_pair_multiset_tb;
  import opm_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam logic signed [31:0] KEY_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;
  localparam int RANDOM_CMDS = 1600;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int TAIL_CYCLES = 80;

  typedef struct packed {
    logic [1:0]       status;
    logic [CNT_W-1:0] match_count;
    logic             lower_found;
    logic [31:0]      lower_a;
    logic [31:0]      lower_d;
    logic [CNT_W-1:0] lower_count;
    logic             upper_found;
    logic [31:0]      upper_a;
    logic [31:0]      upper_d;
    logic [CNT_W-1:0] upper_count;
  } lookup_t;

  typedef struct {
    logic [1:0]         cmd;
    logic signed [31:0] a;
    logic signed [31:0] d;
    bit                 may_idle;
    bit                 wait_drain;
  } pending_cmd_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic [1:0]         in_cmd = CMD_QUERY;
  logic signed [31:0] in_key_a = '0;
  logic signed [31:0] in_key_d = '0;
  logic               out_valid;
  logic [1:0]         out_status;
  logic [CNT_W-1:0]   out_match_count;
  logic               out_lower_found;
  logic signed [31:0] out_lower_a;
  logic signed [31:0] out_lower_d;
  logic [CNT_W-1:0]   out_lower_count;
  logic               out_upper_found;
  logic signed [31:0] out_upper_a;
  logic signed [31:0] out_upper_d;
  logic [CNT_W-1:0]   out_upper_count;

  ordered_pair_multiset dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .start           (start),
    .busy            (busy),
    .in_cmd          (in_cmd),
    .in_key_a        (in_key_a),
    .in_key_d        (in_key_d),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_match_count (out_match_count),
    .out_lower_found (out_lower_found),
    .out_lower_a     (out_lower_a),
    .out_lower_d     (out_lower_d),
    .out_lower_count (out_lower_count),
    .out_upper_found (out_upper_found),
    .out_upper_a     (out_upper_a),
    .out_upper_d     (out_upper_d),
    .out_upper_count (out_upper_count)
  );

  always #2 clk = ~clk;

  // Shadow copy of the pair table.
  logic signed [31:0] stored_a [CAPACITY];
  logic signed [31:0] stored_d [CAPACITY];
  logic [CNT_W-1:0]   stored_cnt [CAPACITY];
  bit                 stored_used [CAPACITY];

  pending_cmd_t       cmd_backlog_q [$];
  lookup_t            predicted_lookups_q [$];

  // Pairs that the generated sequence will have stored, used to aim keys at hits.
  logic signed [31:0] gen_pool_a [$];
  logic signed [31:0] gen_pool_d [$];

  int items_accepted = 0;
  int results_seen = 0;
  int mismatches = 0;
  int quiet_cycles = 0;
  int idle_left = 0;
  int total_items = 0;
  int inserts = 0;
  int removes = 0;
  int queries = 0;
  int full_inserts = 0;
  int absent_removes = 0;
  int saturated_inserts = 0;
  int zero_removes = 0;

  lookup_t want;
  lookup_t got;
  bit      bad;
  bit      go;

  function automatic bit orders_below(logic signed [31:0] a1, logic signed [31:0] d1,
                                      logic signed [31:0] a2, logic signed [31:0] d2);
    longint s1;
    longint s2;
    s1 = longint'(a1) + longint'(d1);
    s2 = longint'(a2) + longint'(d2);
    if (s1 != s2) return s1 < s2;
    return a1 < a2;
  endfunction

  task automatic apply_command(input logic [1:0] op, input logic signed [31:0] ka,
                               input logic signed [31:0] kd);
    int hit;
    int free_idx;
    int lo;
    int hi;
    lookup_t r;
    hit = -1;
    free_idx = -1;
    lo = -1;
    hi = -1;
    r = '0;
    r.status = ST_DONE;
    for (int i = 0; i < CAPACITY; i++) begin
      if (!stored_used[i]) begin
        if (free_idx < 0) free_idx = i;
      end else if (stored_a[i] == ka && stored_d[i] == kd) begin
        hit = i;
      end
    end
    if (op == CMD_INSERT) begin
      inserts++;
      if (hit >= 0) begin
        if (stored_cnt[hit] != CNT_MAX) stored_cnt[hit]++;
        else saturated_inserts++;
      end else if (free_idx < 0) begin
        r.status = ST_FULL;
        full_inserts++;
      end else begin
        stored_a[free_idx] = ka;
        stored_d[free_idx] = kd;
        stored_cnt[free_idx] = CNT_W'(1);
        stored_used[free_idx] = 1'b1;
        hit = free_idx;
      end
    end else if (op == CMD_REMOVE) begin
      removes++;
      if (hit < 0) begin
        r.status = ST_ABSENT;
        absent_removes++;
      end else if (stored_cnt[hit] != 0) begin
        stored_cnt[hit]--;
      end else begin
        zero_removes++;
      end
    end else begin
      // The unused code behaves as a query.
      queries++;
    end
    if (hit >= 0) r.match_count = stored_cnt[hit];

    // Entries at count zero still take part in the neighbor search.
    for (int i = 0; i < CAPACITY; i++) begin
      if (!stored_used[i]) continue;
      if (orders_below(stored_a[i], stored_d[i], ka, kd)) begin
        if (lo < 0 || orders_below(stored_a[lo], stored_d[lo], stored_a[i], stored_d[i]))
          lo = i;
      end else if (orders_below(ka, kd, stored_a[i], stored_d[i])) begin
        if (hi < 0 || orders_below(stored_a[i], stored_d[i], stored_a[hi], stored_d[hi]))
          hi = i;
      end
    end
    if (lo >= 0) begin
      r.lower_found = 1'b1;
      r.lower_a = stored_a[lo];
      r.lower_d = stored_d[lo];
      r.lower_count = stored_cnt[lo];
    end
    if (hi >= 0) begin
      r.upper_found = 1'b1;
      r.upper_a = stored_a[hi];
      r.upper_d = stored_d[hi];
      r.upper_count = stored_cnt[hi];
    end
    predicted_lookups_q.push_back(r);
  endtask

  function automatic bit pool_holds(logic signed [31:0] a, logic signed [31:0] d);
    foreach (gen_pool_a[i])
      if (gen_pool_a[i] == a && gen_pool_d[i] == d) return 1'b1;
    return 1'b0;
  endfunction

  task automatic queue_cmd(input logic [1:0] op, input logic signed [31:0] a,
                           input logic signed [31:0] d, input bit may_idle,
                           input bit wait_drain);
    pending_cmd_t p;
    p.cmd = op;
    p.a = a;
    p.d = d;
    p.may_idle = may_idle;
    p.wait_drain = wait_drain;
    cmd_backlog_q.push_back(p);
    if (op == CMD_INSERT && !pool_holds(a, d) && gen_pool_a.size() < CAPACITY) begin
      gen_pool_a.push_back(a);
      gen_pool_d.push_back(d);
    end
  endtask

  function automatic logic signed [31:0] pick_edge_value();
    case ($urandom_range(0, 4))
      0: return KEY_MIN;
      1: return KEY_MAX;
      2: return 32'sd0;
      3: return -32'sd1;
      default: return 32'sd1;
    endcase
  endfunction

  function automatic bit check_field(string fname, logic [31:0] act, logic [31:0] exp_val);
    if (act === exp_val) return 1'b0;
    if (mismatches < 10)
      $display("%0t: result %0d field %s expected %08h got %08h",
               $realtime, results_seen, fname, exp_val, act);
    return 1'b1;
  endfunction

  // Driver: presents the head of the backlog and retires it on acceptance.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) begin
        apply_command(in_cmd, in_key_a, in_key_d);
        items_accepted++;
        void'(cmd_backlog_q.pop_front());
      end
      if (idle_left > 0) begin
        idle_left--;
        go = 1'b0;
      end else if (cmd_backlog_q.size() == 0) begin
        go = 1'b0;
      end else if (cmd_backlog_q[0].wait_drain && results_seen != items_accepted) begin
        go = 1'b0;
      end else if (cmd_backlog_q[0].may_idle && $urandom_range(0, 11) == 0) begin
        idle_left = $urandom_range(0, 17);
        go = 1'b0;
      end else begin
        go = 1'b1;
      end
      start <= go;
      if (go) begin
        in_cmd <= cmd_backlog_q[0].cmd;
        in_key_a <= cmd_backlog_q[0].a;
        in_key_d <= cmd_backlog_q[0].d;
      end
    end
  end

  // Monitor: results cannot be held off, so every strobe is checked as it comes.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen <= results_seen + 1;
      if (predicted_lookups_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: result %0d arrived with nothing outstanding", $realtime, results_seen);
        mismatches++;
      end else begin
        want = predicted_lookups_q.pop_front();
        got = {out_status, out_match_count, out_lower_found, out_lower_a, out_lower_d,
               out_lower_count, out_upper_found, out_upper_a, out_upper_d, out_upper_count};
        bad = 1'b0;
        bad |= check_field("status", 32'(got.status), 32'(want.status));
        bad |= check_field("match_count", 32'(got.match_count), 32'(want.match_count));
        bad |= check_field("lower_found", 32'(got.lower_found), 32'(want.lower_found));
        bad |= check_field("lower_a", got.lower_a, want.lower_a);
        bad |= check_field("lower_d", got.lower_d, want.lower_d);
        bad |= check_field("lower_count", 32'(got.lower_count), 32'(want.lower_count));
        bad |= check_field("upper_found", 32'(got.upper_found), 32'(want.upper_found));
        bad |= check_field("upper_a", got.upper_a, want.upper_a);
        bad |= check_field("upper_d", got.upper_d, want.upper_d);
        bad |= check_field("upper_count", 32'(got.upper_count), 32'(want.upper_count));
        if (bad) mismatches++;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (start && !busy) || out_valid) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("Watchdog: no item or result for %0d cycles, %0d of %0d results seen",
             WATCHDOG_LIMIT, results_seen, total_items);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int sel;
    int idx;
    int k;
    int reuse_pct;
    int tie_pct;
    logic [1:0] op;
    logic signed [31:0] a;
    logic signed [31:0] d;
    bit may_idle;

    // Empty table and absent remove, then raise one pair's count a few times
    // while the table is small so each command is short.
    queue_cmd(CMD_QUERY, 32'sd0, 32'sd0, 1'b1, 1'b0);
    queue_cmd(CMD_REMOVE, 32'sd5, 32'sd5, 1'b1, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd7, -32'sd7, 1'b1, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd7, -32'sd7, 1'b0, 1'b1);
    for (int i = 0; i < 6; i++) queue_cmd(CMD_INSERT, 32'sd7, -32'sd7, 1'b0, 1'b0);
    queue_cmd(CMD_REMOVE, 32'sd7, -32'sd7, 1'b1, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd7, -32'sd7, 1'b1, 1'b0);

    // Extreme keys and equal sums that must be ordered by the first value.
    queue_cmd(CMD_INSERT, KEY_MIN, KEY_MIN, 1'b1, 1'b1);
    queue_cmd(CMD_INSERT, KEY_MAX, KEY_MAX, 1'b1, 1'b0);
    queue_cmd(CMD_INSERT, KEY_MIN, KEY_MAX, 1'b1, 1'b0);
    queue_cmd(CMD_INSERT, KEY_MAX, KEY_MIN, 1'b1, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd0, -32'sd1, 1'b1, 1'b0);
    queue_cmd(CMD_UNUSED, 32'sd0, -32'sd1, 1'b1, 1'b0);
    queue_cmd(CMD_QUERY, 32'sd1, -32'sd2, 1'b1, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd0, -32'sd1, 1'b1, 1'b0);
    // Three removes from count two: the last one finds the count at zero.
    repeat (3) queue_cmd(CMD_REMOVE, 32'sd0, -32'sd1, 1'b1, 1'b0);
    queue_cmd(CMD_QUERY, -32'sd5, 32'sd4, 1'b1, 1'b0);
    queue_cmd(CMD_INSERT, 32'sd0, -32'sd1, 1'b1, 1'b0);
    queue_cmd(CMD_QUERY, KEY_MAX, KEY_MAX, 1'b1, 1'b0);
    queue_cmd(CMD_QUERY, KEY_MIN, KEY_MIN, 1'b1, 1'b0);
    queue_cmd(CMD_REMOVE, KEY_MIN, 32'sd0, 1'b1, 1'b0);

    for (int i = 0; i < RANDOM_CMDS; i++) begin
      sel = $urandom_range(0, 19);
      if (sel < 8) op = CMD_INSERT;
      else if (sel < 13) op = CMD_REMOVE;
      else if (sel < 19) op = CMD_QUERY;
      else op = CMD_UNUSED;
      // Inserts mostly hit stored pairs so the table fills over about half the run.
      reuse_pct = (op == CMD_INSERT) ? 75 : 50;
      tie_pct = reuse_pct + ((op == CMD_INSERT) ? 10 : 20);
      sel = $urandom_range(0, 99);
      idx = $urandom_range(0, gen_pool_a.size() - 1);
      if (sel < reuse_pct) begin
        a = gen_pool_a[idx];
        d = gen_pool_d[idx];
      end else if (sel < tie_pct) begin
        k = $urandom_range(1, 4);
        if ($urandom_range(0, 1)) k = -k;
        a = gen_pool_a[idx] + k;
        d = gen_pool_d[idx] - k;
      end else if (sel < tie_pct + 5 + (op == CMD_INSERT ? 0 : 5)) begin
        a = pick_edge_value();
        d = $urandom_range(0, 1) ? pick_edge_value() : $urandom;
      end else begin
        a = $urandom;
        d = $urandom;
      end
      may_idle = !(i >= RANDOM_CMDS * 85 / 100 || (i / 100) % 5 == 3);
      queue_cmd(op, a, d, may_idle, i % 250 == 0);
    end

    // Make sure the table ends up full and a new pair is turned away.
    while (gen_pool_a.size() < CAPACITY) queue_cmd(CMD_INSERT, $urandom, $urandom, 1'b0, 1'b0);
    queue_cmd(CMD_INSERT, $urandom, $urandom, 1'b0, 1'b0);
    queue_cmd(CMD_QUERY, $urandom, $urandom, 1'b0, 1'b0);
    total_items = cmd_backlog_q.size();

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    while (results_seen != total_items) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (predicted_lookups_q.size() != 0) begin
      $display("%0d predicted results never arrived", predicted_lookups_q.size());
      mismatches++;
    end
    $display("Ran %0d commands: %0d inserts, %0d removes, %0d queries; %0d mismatching results",
             items_accepted, inserts, removes, queries, mismatches);
    $display("Saw %0d inserts into a full table, %0d at max count, %0d absent and %0d zero removes",
             full_inserts, saturated_inserts, absent_removes, zero_removes);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+rtl
rtl/opm_pkg.sv
rtl/opm_slot_mem.sv
rtl/opm_order_unit.sv
rtl/ordered_pair_multiset.sv
dv/ordered_pair_multiset_tb.sv
